// ===== rtl/zcpt_pkg.sv =====
// Zero-crossing pitch tracker: shared types, widths and constants.
// No dependencies; compile first.
`default_nettype none

package zcpt_pkg;

  localparam int RATE_WIDTH  = 18;
  localparam int COUNT_WIDTH = 15;
  localparam int NOTE_WIDTH  = 16;

  typedef logic [RATE_WIDTH-1:0]  rate_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [NOTE_WIDTH-1:0]  note_t;
  typedef logic [1:0]             sign_t;

  // Sign of the previous sample
  localparam sign_t SIGN_ZERO = 2'd0;
  localparam sign_t SIGN_POS  = 2'd1;
  localparam sign_t SIGN_NEG  = 2'd2;

  localparam rate_t  RATE_RESET   = 18'd44100;
  localparam count_t WINDOW_RESET = count_t'(44100 * 12 / 100);
  localparam count_t MIN_WINDOW   = 15'd256;
  localparam logic [7:0] WLEN_DIVISOR = 8'd100;

  // Pitch class wraps at 12.0 in Q4.12
  localparam note_t NOTE_MOD = 16'd49152;

  // Bit-serial multiplier operand width (Q30 mantissa plus one)
  localparam int MUL_WIDTH = 31;
  localparam logic [MUL_WIDTH-1:0] W_NEW = 31'd2294;

  // log2 in Q16 with a 6-bit integer part
  localparam int LOG_WIDTH = 22;

  // 189.0 in Q16 plus the rounding half of the Q16 to Q12 step
  localparam logic [26:0] CLASS_BIAS = 27'(189 * 65536 + 8);

endpackage

`default_nettype wire

// ===== rtl/zcpt_sample_if.sv =====
// Sample channel of the zero-crossing pitch tracker: valid/ready plus one sample.
// No package dependency.
`default_nettype none

interface zcpt_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/zcpt_result_if.sv =====
// Result channel of the zero-crossing pitch tracker: smoothed note and flags.
// Depends on zcpt_pkg.
`default_nettype none

interface zcpt_result_if
  import zcpt_pkg::*;
();
  logic  valid;
  logic  ready;
  note_t detected_note;
  logic  window_closed;
  logic  estimate_accepted;

  modport source (output valid, output detected_note, output window_closed,
                  output estimate_accepted, input ready);
  modport sink   (input valid, input detected_note, input window_closed,
                  input estimate_accepted, output ready);
endinterface

`default_nettype wire

// ===== rtl/zero_crossing_pitch_class_tracker_top.sv =====
// Zero-crossing pitch-class tracker: counts sign crossings per window, then
// estimates the pitch class with bit-serial multiply, log2 and smoothing.
// Depends on zcpt_pkg, zcpt_sample_if and zcpt_result_if.
//
//   channel | kind               | transaction carries
//   --------+--------------------+----------------------------------------------
//   audio   | sink, valid/ready  | sample
//   pitch   | source, valid/ready| detected_note, window_closed, estimate_accepted
//   cfg     | write enable, data | sample_rate_hz
//
// A sample that does not end a window passes the accept and result load states.
// A sample that ends a window has one 31-step shift-add multiplier form
// c*rate and, if that is in range, two log2 runs of normalising shifts and
// 16 squarings each, and the smoothing product.
// A configuration write restarts a serial divide for the window length; no
// sample is accepted meanwhile. Reset (rst, synchronous) clears counters,
// note and rate to 44100. A stalled pitch output holds the next result in
// the load state, after the current sample has been accepted.
`default_nettype none

module zero_crossing_pitch_class_tracker_top
  import zcpt_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  rate_t         cfg_data,
  zcpt_sample_if.sink   audio,
  zcpt_result_if.source pitch
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WLEN    = 4'd1;
  localparam logic [3:0] S_WFIN    = 4'd2;
  localparam logic [3:0] S_NUM_MUL = 4'd3;
  localparam logic [3:0] S_RANGE   = 4'd4;
  localparam logic [3:0] S_NORM    = 4'd5;
  localparam logic [3:0] S_SQ_MUL  = 4'd6;
  localparam logic [3:0] S_SQ_END  = 4'd7;
  localparam logic [3:0] S_DIFF    = 4'd8;
  localparam logic [3:0] S_CLASS   = 4'd9;
  localparam logic [3:0] S_MOD     = 4'd10;
  localparam logic [3:0] S_SMSET   = 4'd11;
  localparam logic [3:0] S_SM_MUL  = 4'd12;
  localparam logic [3:0] S_SM_END  = 4'd13;
  localparam logic [3:0] S_PUSH    = 4'd14;

  // Control state
  logic [3:0] state;
  rate_t      rate;
  count_t     window_len;
  sign_t      prev_sign;
  count_t     ccount;
  count_t     wcount;
  note_t      note;
  logic       out_valid;

  // Payload and working registers
  note_t                  out_note;
  logic                   out_closed;
  logic                   out_acc;
  logic                   res_closed;
  logic                   res_acc;
  count_t                 wn;
  logic [21:0]            n80;
  logic [26:0]            n2400;
  logic [24:0]            n880;
  logic [MUL_WIDTH-1:0]   mcand;
  logic [MUL_WIDTH-1:0]   mplier;
  logic [MUL_WIDTH-1:0]   hi;
  logic [MUL_WIDTH-1:0]   lo;
  logic [4:0]             mcnt;
  logic [32:0]            lx;
  logic [5:0]             le;
  logic [15:0]            frac;
  logic [3:0]             iter;
  logic                   second_log;
  logic [LOG_WIDTH-1:0]   l1;
  logic [LOG_WIDTH-1:0]   l2;
  logic [26:0]            d12;
  logic [22:0]            rmod;
  logic                   sm_neg;
  logic [21:0]            dv;
  logic [6:0]             drem;
  logic [4:0]             dcnt;

  // Combinational helpers
  logic                   sample_neg;
  logic                   sample_zero;
  sign_t                  sample_sign;
  logic                   crossing;
  count_t                 ccount_next;
  count_t                 wcount_next;
  logic                   close_now;
  logic                   out_free;
  logic                   mul_step;
  logic                   mul_last;
  logic [MUL_WIDTH:0]     msum;
  logic [MUL_WIDTH:0]     sq_r;
  logic [MUL_WIDTH-1:0]   sq_m;
  logic [15:0]            frac_next;
  logic [LOG_WIDTH-1:0]   log_val;
  logic [32:0]            num;
  logic [7:0]             dtrial;
  logic                   dbit;
  logic signed [22:0]     ldiff;
  logic [26:0]            ldiff_x12;
  logic [26:0]            v_rnd;
  logic                   class_below;
  note_t                  rdiff_up;
  note_t                  rdiff_dn;
  logic [31:0]            sm_base;
  logic [31:0]            sm_sum;
  logic [21:0]            rate_x12;

  // Handshake
  assign audio.ready             = (state == S_IDLE) && !cfg_we;
  assign pitch.valid             = out_valid;
  assign pitch.detected_note     = out_note;
  assign pitch.window_closed     = out_closed;
  assign pitch.estimate_accepted = out_acc;
  assign out_free                = !out_valid || pitch.ready;

  // Crossing detection and counters for the incoming sample
  assign sample_neg  = audio.sample[SAMPLE_WIDTH-1];
  assign sample_zero = (audio.sample == '0);
  assign sample_sign = sample_zero ? SIGN_ZERO : (sample_neg ? SIGN_NEG : SIGN_POS);
  assign crossing    = ((prev_sign == SIGN_NEG) && !sample_neg) ||
                       ((prev_sign == SIGN_POS) && (sample_neg || sample_zero));
  assign ccount_next = crossing ? ccount + 1'b1 : ccount;
  assign wcount_next = wcount + 1'b1;
  assign close_now   = (wcount_next >= window_len);

  // Shift-add multiplier step, multiplier bits taken LSB first
  assign mul_step = (state == S_NUM_MUL) || (state == S_SQ_MUL) || (state == S_SM_MUL);
  assign mul_last = (mcnt == 5'(MUL_WIDTH - 1));
  assign msum     = {1'b0, hi} + (mplier[0] ? {1'b0, mcand} : '0);

  // Square result >> 30, renormalised to [1.0, 2.0)
  assign sq_r      = {hi, lo[MUL_WIDTH-1]};
  assign sq_m      = sq_r[MUL_WIDTH] ? sq_r[MUL_WIDTH:1] : sq_r[MUL_WIDTH-1:0];
  assign frac_next = {frac[14:0], sq_r[MUL_WIDTH]};
  assign log_val   = {le, frac_next};
  assign num       = {hi[1:0], lo};

  // Window length divide by 100, one quotient bit a cycle
  assign rate_x12 = 22'({cfg_data, 3'b000}) + 22'({cfg_data, 2'b00});
  assign dtrial   = {drem, dv[21]};
  assign dbit     = (dtrial >= WLEN_DIVISOR);

  // Pitch class: 189 + 12*(log2(c*rate) - log2(880*n)), rounded to Q12
  assign ldiff     = signed'({1'b0, l1}) - signed'({1'b0, l2});
  assign ldiff_x12 = (27'(ldiff) << 3) + (27'(ldiff) << 2);
  assign v_rnd     = CLASS_BIAS + d12;

  // Smoothing: old + 2294*(class - old)/2^16, rounded
  assign class_below = (rmod[15:0] < note);
  assign rdiff_up    = rmod[15:0] - note;
  assign rdiff_dn    = note - rmod[15:0];
  assign sm_base     = {note, 16'h8000};
  assign sm_sum      = sm_neg ? sm_base - {1'b0, lo} : sm_base + {1'b0, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rate       <= RATE_RESET;
      window_len <= WINDOW_RESET;
      prev_sign  <= SIGN_ZERO;
      ccount     <= '0;
      wcount     <= '0;
      note       <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Drop the output once taken, unless the load below refills it
      if (out_valid && pitch.ready && !((state == S_PUSH) && !cfg_we)) begin
        out_valid <= 1'b0;
      end

      // Advance the shared multiplier
      if (mul_step) begin
        hi     <= msum[MUL_WIDTH:1];
        lo     <= {msum[0], lo[MUL_WIDTH-1:1]};
        mplier <= mplier >> 1;
        mcnt   <= mcnt + 1'b1;
      end

      if (cfg_we) begin
        // Take the new rate and restart the window length divide
        rate  <= cfg_data;
        dv    <= rate_x12;
        drem  <= '0;
        dcnt  <= '0;
        state <= S_WLEN;
      end else begin
        case (state)
          S_IDLE: begin
            if (audio.valid) begin
              prev_sign <= sample_sign;
              if (close_now) begin
                ccount <= '0;
                wcount <= '0;
                wn     <= wcount_next;
                mcand  <= MUL_WIDTH'(rate);
                mplier <= MUL_WIDTH'(ccount_next);
                hi     <= '0;
                mcnt   <= '0;
                state  <= S_NUM_MUL;
              end else begin
                ccount     <= ccount_next;
                wcount     <= wcount_next;
                res_closed <= 1'b0;
                res_acc    <= 1'b0;
                state      <= S_PUSH;
              end
            end
          end

          S_WLEN: begin
            drem <= dbit ? 7'(dtrial - WLEN_DIVISOR) : dtrial[6:0];
            dv   <= {dv[20:0], dbit};
            dcnt <= dcnt + 1'b1;
            if (dcnt == 5'd21) begin
              state <= S_WFIN;
            end
          end

          S_WFIN: begin
            window_len <= (dv < 22'(MIN_WINDOW)) ? MIN_WINDOW : dv[COUNT_WIDTH-1:0];
            state      <= S_IDLE;
          end

          S_NUM_MUL: begin
            // Scale the window length for the range test and the log
            n80   <= 22'({wn, 6'b0}) + 22'({wn, 4'b0});
            n2400 <= 27'({wn, 11'b0}) + 27'({wn, 8'b0}) + 27'({wn, 6'b0}) +
                     27'({wn, 5'b0});
            n880  <= 25'({wn, 9'b0}) + 25'({wn, 8'b0}) + 25'({wn, 6'b0}) +
                     25'({wn, 5'b0}) + 25'({wn, 4'b0});
            if (mul_last) begin
              state <= S_RANGE;
            end
          end

          S_RANGE: begin
            if ((num >= 33'(n80)) && (num <= 33'(n2400))) begin
              lx         <= num;
              le         <= 6'd32;
              second_log <= 1'b0;
              state      <= S_NORM;
            end else begin
              res_closed <= 1'b1;
              res_acc    <= 1'b0;
              state      <= S_PUSH;
            end
          end

          S_NORM: begin
            // Shift up until the top bit is set; exponent follows
            if (lx[32]) begin
              mcand <= lx[32:2];
              mplier <= lx[32:2];
              hi    <= '0;
              mcnt  <= '0;
              frac  <= '0;
              iter  <= '0;
              state <= S_SQ_MUL;
            end else begin
              lx <= lx << 1;
              le <= le - 1'b1;
            end
          end

          S_SQ_MUL: begin
            if (mul_last) begin
              state <= S_SQ_END;
            end
          end

          S_SQ_END: begin
            frac   <= frac_next;
            mcand  <= sq_m;
            mplier <= sq_m;
            hi     <= '0;
            mcnt   <= '0;
            iter   <= iter + 1'b1;
            if (iter == 4'd15) begin
              if (!second_log) begin
                l1         <= log_val;
                lx         <= 33'(n880);
                le         <= 6'd32;
                second_log <= 1'b1;
                state      <= S_NORM;
              end else begin
                l2    <= log_val;
                state <= S_DIFF;
              end
            end else begin
              state <= S_SQ_MUL;
            end
          end

          S_DIFF: begin
            d12   <= ldiff_x12;
            state <= S_CLASS;
          end

          S_CLASS: begin
            // Clamp below zero, then drop to Q12
            rmod  <= v_rnd[26] ? '0 : v_rnd[26:4];
            state <= S_MOD;
          end

          S_MOD: begin
            if (rmod >= 23'(NOTE_MOD)) begin
              rmod <= rmod - 23'(NOTE_MOD);
            end else begin
              state <= S_SMSET;
            end
          end

          S_SMSET: begin
            sm_neg <= class_below;
            mcand  <= W_NEW;
            mplier <= class_below ? MUL_WIDTH'(rdiff_dn) : MUL_WIDTH'(rdiff_up);
            hi     <= '0;
            mcnt   <= '0;
            state  <= S_SM_MUL;
          end

          S_SM_MUL: begin
            if (mul_last) begin
              state <= S_SM_END;
            end
          end

          S_SM_END: begin
            note       <= sm_sum[31:16];
            res_closed <= 1'b1;
            res_acc    <= 1'b1;
            state      <= S_PUSH;
          end

          S_PUSH: begin
            // Hold until the output register is free
            if (out_free) begin
              out_valid  <= 1'b1;
              out_note   <= note;
              out_closed <= res_closed;
              out_acc    <= res_acc;
              state      <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cross_count: assert property (@(posedge clk) disable iff (rst)
    ccount <= wcount)
    else $error("crossing count exceeds window count");

  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_MUL) && (mcnt == '0) |-> mcand[MUL_WIDTH-1] && mplier[MUL_WIDTH-1])
    else $error("log2 mantissa not normalised at square start");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SMSET) |-> rmod < 23'(NOTE_MOD))
    else $error("pitch class not reduced below 12.0");

  a_note_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SM_END) |=> note < NOTE_MOD)
    else $error("smoothed note out of range");

  a_wlen_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_WFIN) |=> window_len >= MIN_WINDOW)
    else $error("window length below minimum");
`endif

endmodule

`default_nettype wire
